// ===== rtl/core/dq_pkg.sv =====
// Shared types and constants for the double-ended queue.
package dq_pkg;

  localparam int unsigned DqDepthDef     = 1024;
  localparam int unsigned DqDataWidthDef = 32;
  localparam int unsigned FieldW         = 32;

  typedef enum logic [2:0] {
    ACT_PUSH_FRONT = 3'd0,
    ACT_PUSH_BACK  = 3'd1,
    ACT_POP_FRONT  = 3'd2,
    ACT_POP_BACK   = 3'd3,
    ACT_SIZE       = 3'd4,
    ACT_EMPTY      = 3'd5,
    ACT_PEEK_FRONT = 3'd6,
    ACT_PEEK_BACK  = 3'd7
  } action_e;

  // Result waiting for the store read or for the output register.
  typedef struct packed {
    logic              valid;
    logic              from_ram;
    logic              status;
    logic              ovf;
    logic [FieldW-1:0] data;
  } pend_t;

endpackage

// ===== rtl/core/dq_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module dq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Hold the last read word until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/double_ended_queue.sv =====
// Bounded double-ended queue of signed words in a circular RAM.
//
//  channel | direction | handshake            | payload
//  in      | to block  | in_valid_i/in_stall_o | in_action_i, in_value_i
//  out     | from block| out_valid_o/out_stall_i| out_data_o, out_status_o,
//          |           |                      | out_overflow_seen_o
//
// Pushes produce no result and may follow back to back. An item with a result
// waits in the pending register; the next beat is taken once that register
// has handed its result to the output register, so no new item is taken while
// a result is pending. Reset clears head, count and overflow; the RAM is not
// cleared. A stalled output holds its beat and, behind it, one pending result.
module double_ended_queue
  import dq_pkg::*;
#(
  parameter int unsigned DEPTH      = DqDepthDef,
  parameter int unsigned DATA_WIDTH = DqDataWidthDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [2:0]        in_action_i,
  input  logic [FieldW-1:0] in_value_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [FieldW-1:0] out_data_o,
  output logic              out_status_o,
  output logic              out_overflow_seen_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned SW = CW + 1;
  localparam logic [SW-1:0] DepthS   = SW'(DEPTH);
  localparam logic [AW-1:0] LastAddr = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FullCnt  = CW'(DEPTH);

  logic [AW-1:0] head_q, head_d;
  logic [CW-1:0] count_q, count_d;
  logic          ovf_q, ovf_d;
  pend_t         pend_q, pend_d;
  logic          out_valid_q, out_valid_d;
  logic [FieldW-1:0] out_data_q, out_data_d;
  logic          out_status_q, out_status_d;
  logic          out_ovf_q, out_ovf_d;

  logic            in_acc;
  logic            out_free;
  action_e         act;
  logic [CW-1:0]   off;
  logic [SW-1:0]   slot_sum;
  logic [AW-1:0]   slot_addr;
  logic [AW-1:0]   head_dec, head_inc;
  logic            ram_we, ram_re;
  logic [AW-1:0]   ram_waddr, ram_raddr;
  logic [DATA_WIDTH-1:0] ram_wdata, ram_rdata;
  logic [FieldW-1:0]     rd_ext;

  assign in_stall_o = pend_q.valid;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign act        = action_e'(in_action_i);

  // Back slot: head + count for push back, head + count - 1 for reads.
  assign off       = (act == ACT_PUSH_BACK) ? count_q : count_q - 1'b1;
  assign slot_sum  = SW'(head_q) + SW'(off);
  assign slot_addr = (slot_sum >= DepthS) ? AW'(slot_sum - DepthS) : AW'(slot_sum);
  assign head_dec  = (head_q == '0) ? LastAddr : head_q - 1'b1;
  assign head_inc  = (head_q == LastAddr) ? '0 : head_q + 1'b1;

  if (DATA_WIDTH >= FieldW) begin : g_wide
    assign ram_wdata = DATA_WIDTH'($signed(in_value_i));
    assign rd_ext    = ram_rdata[FieldW-1:0];
  end else begin : g_narrow
    assign ram_wdata = in_value_i[DATA_WIDTH-1:0];
    assign rd_ext    = {{(FieldW - DATA_WIDTH){ram_rdata[DATA_WIDTH-1]}}, ram_rdata};
  end

  always_comb begin
    head_d    = head_q;
    count_d   = count_q;
    ovf_d     = ovf_q;
    pend_d    = pend_q;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_waddr = slot_addr;
    ram_raddr = slot_addr;

    out_valid_d  = out_valid_q && out_stall_i;
    out_data_d   = out_data_q;
    out_status_d = out_status_q;
    out_ovf_d    = out_ovf_q;

    // Advance the pending result into the output register.
    if (pend_q.valid && out_free) begin
      out_valid_d  = 1'b1;
      out_data_d   = pend_q.from_ram ? rd_ext : pend_q.data;
      out_status_d = pend_q.status;
      out_ovf_d    = pend_q.ovf;
      pend_d.valid = 1'b0;
    end

    if (in_acc) begin
      pend_d.valid    = 1'b1;
      pend_d.from_ram = 1'b0;
      pend_d.status   = 1'b0;
      pend_d.ovf      = ovf_q;
      pend_d.data     = '0;
      unique case (act) inside
        ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
          pend_d.valid = 1'b0;
          if (count_q == FullCnt) begin
            ovf_d = 1'b1;
          end else begin
            ram_we  = 1'b1;
            count_d = count_q + 1'b1;
            if (act == ACT_PUSH_FRONT) begin
              head_d    = head_dec;
              ram_waddr = head_dec;
            end
          end
        end
        ACT_SIZE: begin
          pend_d.data = FieldW'(count_q);
        end
        ACT_EMPTY: begin
          pend_d.data = FieldW'(count_q == '0);
        end
        ACT_POP_FRONT, ACT_PEEK_FRONT, ACT_POP_BACK, ACT_PEEK_BACK: begin
          if (count_q == '0) begin
            pend_d.status = 1'b1;
            pend_d.data   = '1;
          end else begin
            ram_re          = 1'b1;
            pend_d.from_ram = 1'b1;
            if (act == ACT_POP_FRONT || act == ACT_PEEK_FRONT) begin
              ram_raddr = head_q;
            end
            if (act == ACT_POP_FRONT) begin
              head_d = head_inc;
            end
            if (act == ACT_POP_FRONT || act == ACT_POP_BACK) begin
              count_d = count_q - 1'b1;
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q       <= '0;
      count_q      <= '0;
      ovf_q        <= 1'b0;
      pend_q       <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      head_q       <= head_d;
      count_q      <= count_d;
      ovf_q        <= ovf_d;
      pend_q       <= pend_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q      <= out_data_d;
    out_status_q    <= out_status_d;
    out_ovf_q       <= out_ovf_d;
  end

  dq_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o         = out_valid_q;
  assign out_data_o          = out_data_q;
  assign out_status_o        = out_status_q;
  assign out_overflow_seen_o = out_ovf_q;

  a_count_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FullCnt)
    else $error("element count beyond depth");

  a_ovf_sticky : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |=> ovf_q)
    else $error("overflow flag cleared");

  a_full_push : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (act == ACT_PUSH_FRONT || act == ACT_PUSH_BACK) && count_q == FullCnt
    |=> ovf_q && $stable(count_q) && $stable(head_q))
    else $error("push into full queue changed state");

  a_empty_status : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_status_q |-> out_data_q == '1)
    else $error("empty access without all-ones data");

  a_pop_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (act == ACT_POP_FRONT || act == ACT_POP_BACK) && count_q != '0
    |=> count_q == $past(count_q) - 1'b1)
    else $error("pop did not remove one element");

endmodule

// ===== test/testbench.sv =====
// Testbench for double_ended_queue: directed and random traffic checked against a deque model.
module testbench;
  import dq_pkg::*;

  localparam int unsigned Depth      = DqDepthDef;
  localparam int unsigned CycleLimit = 1_000_000;
  localparam int unsigned TailCycles = 32;
  localparam int unsigned PrintLimit = 200;

  typedef struct packed {
    logic [FieldW-1:0] data;
    logic              status;
    logic              overflow;
  } deque_beat_t;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_stall_o;
  logic [2:0]        in_action_i;
  logic [FieldW-1:0] in_value_i;
  logic              out_valid_o;
  logic              out_stall_i;
  logic [FieldW-1:0] out_data_o;
  logic              out_status_o;
  logic              out_overflow_seen_o;

  // Deque contents as the block should hold them.
  logic [FieldW-1:0] dq_store [Depth];
  int unsigned       dq_head     = 0;
  int unsigned       dq_count    = 0;
  logic              dq_overflow = 1'b0;

  deque_beat_t expected_beats [$];
  int unsigned mismatches   = 0;
  int unsigned cycle_count  = 0;
  int unsigned hold_cycles  = 0;
  int unsigned stall_run    = 0;
  bit          stall_enable = 1'b0;
  bit          sender_gaps  = 1'b0;

  double_ended_queue uut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .in_action_i        (in_action_i),
    .in_value_i         (in_value_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .out_data_o         (out_data_o),
    .out_status_o       (out_status_o),
    .out_overflow_seen_o(out_overflow_seen_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Verification failed");
      $finish;
    end
  end

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  always @(posedge clk_i) begin
    if (hold_cycles != 0) begin
      out_stall_i <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else if (stall_run != 0) begin
      out_stall_i <= 1'b1;
      stall_run   <= stall_run - 1;
    end else if (stall_enable && $urandom_range(0, 3) == 0) begin
      out_stall_i <= 1'b1;
      stall_run   <= gap_len();
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  task automatic report_mismatch(input string what, input logic [FieldW-1:0] got,
                                 input logic [FieldW-1:0] want);
    if (mismatches < PrintLimit)
      $display("MISMATCH %s: got %h, expected %h (cycle %0d)", what, got, want, cycle_count);
    mismatches++;
  endtask

  function automatic void predict_deque_action(input action_e act,
                                               input logic [FieldW-1:0] val);
    deque_beat_t beat;
    beat.data   = '0;
    beat.status = 1'b0;
    case (act) inside
      ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
        if (dq_count >= Depth) begin
          dq_overflow = 1'b1;
        end else if (act == ACT_PUSH_FRONT) begin
          dq_head = (dq_head == 0) ? Depth - 1 : dq_head - 1;
          dq_store[dq_head] = val;
          dq_count++;
        end else begin
          dq_store[(dq_head + dq_count) % Depth] = val;
          dq_count++;
        end
        return;
      end
      ACT_SIZE:  beat.data = dq_count;
      ACT_EMPTY: beat.data = FieldW'(dq_count == 0);
      default: begin
        if (dq_count == 0) begin
          beat.data   = '1;
          beat.status = 1'b1;
        end else if (act == ACT_POP_FRONT || act == ACT_PEEK_FRONT) begin
          beat.data = dq_store[dq_head];
          if (act == ACT_POP_FRONT) begin
            dq_head = (dq_head + 1) % Depth;
            dq_count--;
          end
        end else begin
          beat.data = dq_store[(dq_head + dq_count - 1) % Depth];
          if (act == ACT_POP_BACK) dq_count--;
        end
      end
    endcase
    beat.overflow = dq_overflow;
    expected_beats.insert(expected_beats.size(), beat);
  endfunction

  always @(posedge clk_i) begin
    deque_beat_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_beats.size() == 0) begin
        report_mismatch("unexpected result beat", out_data_o, '0);
      end else begin
        want = expected_beats[0];
        expected_beats.delete(0);
        if (out_data_o !== want.data) report_mismatch("data", out_data_o, want.data);
        if (out_status_o !== want.status)
          report_mismatch("status", FieldW'(out_status_o), FieldW'(want.status));
        if (out_overflow_seen_o !== want.overflow)
          report_mismatch("overflow_seen", FieldW'(out_overflow_seen_o),
                          FieldW'(want.overflow));
      end
    end
  end

  // Call at a rising edge; returns at the edge that takes the beat.
  task automatic send_item(input action_e act, input logic [FieldW-1:0] val);
    int unsigned gap;
    gap = sender_gaps ? gap_len() : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    in_action_i <= act;
    in_value_i  <= val;
    do @(posedge clk_i); while (in_stall_o);
    predict_deque_action(act, val);
  endtask

  task automatic pause_until_drained();
    in_valid_i <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [FieldW-1:0] random_value();
    case ($urandom_range(0, 7))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'hFFFF_FFFF;
      3:       return 32'h0000_0000;
      4:       return $urandom_range(0, 15);
      default: return $urandom;
    endcase
  endfunction

  function automatic action_e random_action(input bit grow);
    int unsigned r;
    int unsigned push_pct;
    int unsigned pop_pct;
    r        = $urandom_range(0, 99);
    push_pct = grow ? 55 : 20;
    pop_pct  = grow ? 25 : 50;
    if (r < push_pct) return $urandom_range(0, 1) ? ACT_PUSH_BACK : ACT_PUSH_FRONT;
    if (r < push_pct + pop_pct) return $urandom_range(0, 1) ? ACT_POP_BACK : ACT_POP_FRONT;
    return action_e'($urandom_range(4, 7));
  endfunction

  task automatic run_random_traffic(input int unsigned n_items);
    bit grow;
    grow = 1'b1;
    for (int unsigned i = 0; i < n_items; i++) begin
      // Swing the fill level up and down so the empty case keeps coming back.
      if (i % 100 == 0) grow = (dq_count < 20) ? 1'b1 : ~grow;
      send_item(random_action(grow), random_value());
    end
  endtask

  task automatic test_empty_access();
    send_item(ACT_POP_FRONT, 32'h1234_5678);
    send_item(ACT_POP_BACK, 32'hFFFF_FFFF);
    send_item(ACT_PEEK_FRONT, 32'h0);
    send_item(ACT_PEEK_BACK, 32'h0);
    send_item(ACT_SIZE, 32'h0);
    send_item(ACT_EMPTY, 32'h0);
  endtask

  task automatic test_value_extremes();
    send_item(ACT_PUSH_FRONT, 32'h8000_0000);  // head wraps below zero
    send_item(ACT_PUSH_BACK, 32'h7FFF_FFFF);
    send_item(ACT_PUSH_FRONT, 32'hFFFF_FFFF);
    send_item(ACT_PUSH_BACK, 32'h0000_0000);
    send_item(ACT_PUSH_BACK, 32'h5555_5555);
    send_item(ACT_PUSH_FRONT, 32'hAAAA_AAAA);
    send_item(ACT_SIZE, 32'h0);
    send_item(ACT_EMPTY, 32'h0);
    send_item(ACT_PEEK_FRONT, 32'h0);
    send_item(ACT_PEEK_BACK, 32'h0);
    for (int i = 0; i < 3; i++) begin
      send_item(ACT_POP_FRONT, 32'h0);
      send_item(ACT_POP_BACK, 32'h0);
    end
    send_item(ACT_POP_BACK, 32'h0);
    send_item(ACT_EMPTY, 32'h0);
  endtask

  task automatic test_output_hold_off();
    sender_gaps = 1'b0;
    hold_cycles = 300;
    for (int i = 0; i < 60; i++)
      send_item((i % 3 == 0) ? ACT_PUSH_BACK : action_e'($urandom_range(4, 7)),
                random_value());
    pause_until_drained();
    sender_gaps = 1'b1;
  endtask

  task automatic test_full_store();
    while (dq_count < Depth)
      send_item($urandom_range(0, 1) ? ACT_PUSH_BACK : ACT_PUSH_FRONT, $urandom);
    // Drop these: the store is full.
    send_item(ACT_PUSH_FRONT, 32'hDEAD_0001);
    send_item(ACT_PUSH_BACK, 32'hDEAD_0002);
    send_item(ACT_SIZE, 32'h0);
    send_item(ACT_PEEK_FRONT, 32'h0);
    send_item(ACT_PEEK_BACK, 32'h0);
    send_item(ACT_POP_FRONT, 32'h0);
    send_item(ACT_POP_BACK, 32'h0);
    send_item(ACT_PUSH_BACK, 32'h0BAD_F00D);
    send_item(ACT_PEEK_BACK, 32'h0);
    send_item(ACT_SIZE, 32'h0);
    // Take a stretch off both ends of the nearly full store.
    for (int i = 0; i < 40; i++)
      send_item($urandom_range(0, 1) ? ACT_POP_BACK : ACT_POP_FRONT, $urandom);
    send_item(ACT_SIZE, 32'h0);
  endtask

  initial begin
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    in_action_i <= ACT_SIZE;
    in_value_i  <= '0;
    out_stall_i <= 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_access();
    test_value_extremes();

    stall_enable = 1'b1;
    sender_gaps  = 1'b1;
    run_random_traffic(80);
    test_output_hold_off();
    test_full_store();

    pause_until_drained();
    repeat (TailCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
